// ===== hdl/ihm_pkg.sv =====
package ihm_pkg;

   localparam int ValueWidth = 64;
   localparam logic [63:0] HASH_OFFSET = 64'hc22dbcb72481193b;
   localparam int REM_DIVISOR = 23;
   localparam int SP_BIAS = 11;

   typedef struct packed {
      logic        valid;
      logic [63:0] value;
   } beat_type;

   localparam logic [5:0] PERM_TBL [0:63] = '{
      6'd21, 6'd32, 6'd54, 6'd58, 6'd56, 6'd37, 6'd36, 6'd50,
      6'd34, 6'd14, 6'd15, 6'd6,  6'd43, 6'd59, 6'd9,  6'd13,
      6'd46, 6'd44, 6'd24, 6'd35, 6'd10, 6'd20, 6'd53, 6'd18,
      6'd30, 6'd21, 6'd19, 6'd8,  6'd32, 6'd11, 6'd61, 6'd26,
      6'd22, 6'd55, 6'd0,  6'd17, 6'd28, 6'd2,  6'd23, 6'd5,
      6'd62, 6'd3,  6'd42, 6'd49, 6'd7,  6'd41, 6'd40, 6'd60,
      6'd51, 6'd39, 6'd33, 6'd25, 6'd16, 6'd48, 6'd29, 6'd47,
      6'd4,  6'd57, 6'd63, 6'd45, 6'd52, 6'd31, 6'd1,  6'd38
   };

   function automatic logic [5:0] perm(input logic [5:0] idx);
      return PERM_TBL[idx];
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] v, input logic [5:0] s);
      logic [127:0] w;
      w = {v, v} >> s;
      return w[63:0];
   endfunction

   // residue by 23 through byte weights 256^i mod 23
   function automatic logic [4:0] mod23(input logic [63:0] v);
      logic [13:0] s;
      logic [8:0]  t;
      logic [8:0]  u;
      s = 14'(v[7:0]) + 14'(v[15:8]) * 14'd3 + 14'(v[23:16]) * 14'd9
        + 14'(v[31:24]) * 14'd4 + 14'(v[39:32]) * 14'd12
        + 14'(v[47:40]) * 14'd13 + 14'(v[55:48]) * 14'd16
        + 14'(v[63:56]) * 14'd2;
      t = 9'(s[13:8]) * 9'd3 + 9'(s[7:0]);
      u = 9'(t[8]) * 9'd3 + 9'(t[7:0]);
      if (u >= 9'(8 * REM_DIVISOR)) u = u - 9'(8 * REM_DIVISOR);
      if (u >= 9'(4 * REM_DIVISOR)) u = u - 9'(4 * REM_DIVISOR);
      if (u >= 9'(2 * REM_DIVISOR)) u = u - 9'(2 * REM_DIVISOR);
      if (u >= 9'(REM_DIVISOR)) u = u - 9'(REM_DIVISOR);
      return u[4:0];
   endfunction

endpackage

// ===== hdl/integer_mixing_hash.sv =====
// 64-bit mixing hash of a 64-bit seed, no kept state. One seed is taken every cycle unless the
// output is stalled. A seed passes through one entry stage (offset and rotate), a chain of
// MIX_ROUNDS round cells of eight stages each (set by the two multiplier levels of the
// squaring and the residue reduction), and the output register that holds the final rotate.
// A stalled output freezes the whole chain, so req_ready follows rsp_ready while a result
// is held.
module integer_mixing_hash #(
   parameter int MIX_ROUNDS = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value
);

   ihm_pkg::beat_type chain [MIX_ROUNDS+1];

   logic        en;
   logic        ent_vld_ff;
   logic [63:0] ent_r_ff, ent_r_in, ent_sum;
   logic        out_vld_ff;
   logic [63:0] out_r_ff, out_r_in;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   assign ent_sum  = req_seed_value + ihm_pkg::HASH_OFFSET;
   assign ent_r_in = ihm_pkg::rotr(ent_sum, ihm_pkg::perm(req_seed_value[5:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         ent_vld_ff <= req_valid;
         out_vld_ff <= chain[MIX_ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ent_r_ff <= ent_r_in;
         out_r_ff <= out_r_in;
      end
   end

   assign chain[0].valid = ent_vld_ff;
   assign chain[0].value = ent_r_ff;

   for (genvar g = 0; g < MIX_ROUNDS; g++) begin : g_round
      ihm_round u_round (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .beat_in  (chain[g]),
         .beat_out (chain[g+1])
      );
   end

   assign out_r_in = ihm_pkg::rotr(chain[MIX_ROUNDS].value,
                                   ihm_pkg::perm(chain[MIX_ROUNDS].value[5:0]));

   assign rsp_valid      = out_vld_ff;
   assign rsp_hash_value = out_r_ff;

   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while output stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_tail: assert property (@(posedge clock) disable iff (reset)
      en && chain[MIX_ROUNDS].valid |=> rsp_valid)
      else $error("beat lost at output");

endmodule

// ===== hdl/ihm_round.sv =====
module ihm_round (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  ihm_pkg::beat_type beat_in,
   output ihm_pkg::beat_type beat_out
);

   localparam int Stages = 8;

   logic [Stages-1:0] vld_ff;
   logic [Stages-1:0] vld_in;

   logic [5:0]  p_w, sp_w;
   logic [11:0] rsq_w;
   logic [7:0]  pb_w, pabs_w;
   logic [63:0] prot_w;

   logic [63:0] r_a_ff, r_a_in;
   logic [12:0] k_a_ff, k_a_in;
   logic [14:0] sq_a_ff, sq_a_in;

   logic [63:0] r_b_ff, r_b_in;
   logic [14:0] sq_b_ff;

   logic [63:0] r_c_ff;
   logic [14:0] sq_c_ff;
   logic [63:0] ll_c_ff, ll_c_in;
   logic [31:0] hl_c_ff, hl_c_in;

   logic [63:0] r_d_ff;
   logic [14:0] sq_d_ff;
   logic [63:0] mag_d_ff, mag_d_in, v_d;
   logic        neg_d_ff;

   logic [63:0] r_e_ff;
   logic [14:0] sq_e_ff;
   logic [4:0]  k_e_ff, k_e_in, m_e;
   logic        ng_e_ff, ng_e_in;

   logic [63:0] r_f_ff, r_f_in, prod_f;
   logic [14:0] sq_f_ff;

   logic [63:0] r_g_ff, r_g_in;
   logic [63:0] r_h_ff, r_h_in;

   assign vld_in = {vld_ff[Stages-2:0], beat_in.valid};

   always_comb begin
      rsq_w   = 12'(beat_in.value[5:0]) * 12'(beat_in.value[5:0]);
      p_w     = ihm_pkg::perm(rsq_w[5:0]);
      sp_w    = ihm_pkg::perm(beat_in.value[5:0] + p_w);
      prot_w  = ihm_pkg::rotr({58'b0, p_w}, sp_w);
      pb_w    = prot_w[7:0];
      pabs_w  = pb_w[7] ? 8'(-pb_w) : pb_w;
      r_a_in  = beat_in.value;
      k_a_in  = 13'(p_w) * (13'(sp_w) + 13'(ihm_pkg::SP_BIAS));
      sq_a_in = 15'(16'(pabs_w) * 16'(pabs_w));
   end

   assign r_b_in  = r_a_ff + r_a_ff * 64'(k_a_ff);
   assign ll_c_in = {32'b0, r_b_ff[31:0]} * {32'b0, r_b_ff[31:0]};
   assign hl_c_in = r_b_ff[63:32] * r_b_ff[31:0];

   always_comb begin
      v_d      = ll_c_ff + {hl_c_ff[30:0], 1'b0, 32'b0};
      mag_d_in = v_d[63] ? -v_d : v_d;
   end

   always_comb begin
      m_e = ihm_pkg::mod23(mag_d_ff);
      if (!neg_d_ff) begin
         k_e_in  = m_e + 5'd1;
         ng_e_in = 1'b0;
      end else if (m_e == 5'd0) begin
         k_e_in  = 5'd1;
         ng_e_in = 1'b0;
      end else begin
         k_e_in  = m_e - 5'd1;
         ng_e_in = 1'b1;
      end
   end

   always_comb begin
      prod_f = r_e_ff * 64'(k_e_ff);
      r_f_in = ng_e_ff ? -prod_f : prod_f;
   end

   assign r_g_in = r_f_ff ^ (r_f_ff * 64'(sq_f_ff));
   assign r_h_in = ihm_pkg::rotr(r_g_ff, ihm_pkg::perm(r_g_ff[5:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_a_ff   <= r_a_in;
         k_a_ff   <= k_a_in;
         sq_a_ff  <= sq_a_in;
         r_b_ff   <= r_b_in;
         sq_b_ff  <= sq_a_ff;
         r_c_ff   <= r_b_ff;
         sq_c_ff  <= sq_b_ff;
         ll_c_ff  <= ll_c_in;
         hl_c_ff  <= hl_c_in;
         r_d_ff   <= r_c_ff;
         sq_d_ff  <= sq_c_ff;
         mag_d_ff <= mag_d_in;
         neg_d_ff <= v_d[63];
         r_e_ff   <= r_d_ff;
         sq_e_ff  <= sq_d_ff;
         k_e_ff   <= k_e_in;
         ng_e_ff  <= ng_e_in;
         r_f_ff   <= r_f_in;
         sq_f_ff  <= sq_e_ff;
         r_g_ff   <= r_g_in;
         r_h_ff   <= r_h_in;
      end
   end

   assign beat_out.valid = vld_ff[Stages-1];
   assign beat_out.value = r_h_ff;

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("round valid bits moved while stalled");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      en && beat_in.valid |=> vld_ff[0])
      else $error("beat lost entering round");

   a_factor: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> k_e_ff <= 5'(ihm_pkg::REM_DIVISOR))
      else $error("remainder factor out of range");

endmodule
